@@ rtl/core/epoch_seconds_to_calendar_unit_macros.svh @@
// Assertion macros for the calendar unit datapath.
// Expects signals named clock and reset in the including scope.
`ifndef EPOCH_SECONDS_TO_CALENDAR_UNIT_MACROS_SVH
`define EPOCH_SECONDS_TO_CALENDAR_UNIT_MACROS_SVH

// same-cycle implication
`define ESC_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ESC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/esc_pkg.sv @@
// Types and constants for the epoch-seconds to calendar unit.
// No dependencies; used by esc_ctrl, esc_dpath and the top level.
package esc_pkg;

   localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
   localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
   localparam logic [5:0]  SECS_PER_MIN  = 6'd60;
   localparam logic [2:0]  DAYS_PER_WEEK = 3'd7;
   // reciprocals: 86400 = 128 * 675, 3600 = 16 * 225, 60 = 4 * 15
   localparam logic [25:0] DAY_RECIP     = 26'd50903317;   // ceil(2^35 / 675)
   localparam logic [16:0] WEEK_RECIP    = 17'd74899;      // ceil(2^19 / 7)
   localparam logic [13:0] HOUR_RECIP    = 14'd9321;       // ceil(2^21 / 225)
   localparam logic [10:0] MIN_RECIP     = 11'd1093;       // ceil(2^14 / 15)
   localparam logic [11:0] EPOCH_YEAR    = 12'd1970;
   localparam logic [8:0]  EPOCH_CYC_POS = 9'd370;
   localparam logic [8:0]  LAST_CYC_POS  = 9'd399;
   localparam logic [3:0]  EPOCH_WDAY    = 4'd4;
   localparam logic [3:0]  LAST_MONTH    = 4'd11;

   localparam logic [4:0] MONTH_DAYS [12] = '{
      5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
      5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
   };

   typedef enum logic [3:0] {
      S_IDLE,
      S_DAY,
      S_SECS,
      S_WDAY,
      S_HOUR,
      S_MIN,
      S_YEAR,
      S_MONTH,
      S_EMIT
   } state_type;

   typedef enum logic [2:0] {
      OP_DAY,
      OP_SECS,
      OP_WDAY,
      OP_HOUR,
      OP_MIN
   } div_op_type;

   typedef struct packed {
      logic       load;
      logic       calc_step;
      div_op_type op;
      logic       year_step;
      logic       month_step;
      logic       emit;
   } cmd_type;

   typedef struct packed {
      logic year_done;
      logic month_done;
      logic out_busy;
   } sts_type;

   function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
      logic [4:0] len;
      if (m > LAST_MONTH) begin
         len = 5'd31;
      end else if (m == 4'd1 && leap) begin
         len = 5'd29;
      end else begin
         len = MONTH_DAYS[m];
      end
      return len;
   endfunction

endpackage

@@ rtl/core/esc_ctrl.sv @@
// Sequencer for the calendar unit: steps the division ops, year and month loops.
// Depends on esc_pkg; drives esc_dpath through cmd_type, reads sts_type.
module esc_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  esc_pkg::sts_type sts,
   output esc_pkg::cmd_type cmd
);

   esc_pkg::state_type state_ff;
   esc_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= esc_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      req_tready     = 1'b0;
      cmd.load       = 1'b0;
      cmd.calc_step  = 1'b0;
      cmd.op         = esc_pkg::OP_DAY;
      cmd.year_step  = 1'b0;
      cmd.month_step = 1'b0;
      cmd.emit       = 1'b0;
      case (state_ff)
         esc_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = esc_pkg::S_DAY;
            end
         end
         esc_pkg::S_DAY: begin
            cmd.calc_step = 1'b1;
            cmd.op        = esc_pkg::OP_DAY;
            state_in      = esc_pkg::S_SECS;
         end
         esc_pkg::S_SECS: begin
            cmd.calc_step = 1'b1;
            cmd.op        = esc_pkg::OP_SECS;
            state_in      = esc_pkg::S_WDAY;
         end
         esc_pkg::S_WDAY: begin
            cmd.calc_step = 1'b1;
            cmd.op        = esc_pkg::OP_WDAY;
            state_in      = esc_pkg::S_HOUR;
         end
         esc_pkg::S_HOUR: begin
            cmd.calc_step = 1'b1;
            cmd.op        = esc_pkg::OP_HOUR;
            state_in      = esc_pkg::S_MIN;
         end
         esc_pkg::S_MIN: begin
            cmd.calc_step = 1'b1;
            cmd.op        = esc_pkg::OP_MIN;
            state_in      = esc_pkg::S_YEAR;
         end
         esc_pkg::S_YEAR: begin
            cmd.year_step = 1'b1;
            if (sts.year_done) state_in = esc_pkg::S_MONTH;
         end
         esc_pkg::S_MONTH: begin
            cmd.month_step = 1'b1;
            if (sts.month_done) state_in = esc_pkg::S_EMIT;
         end
         esc_pkg::S_EMIT: begin
            if (!sts.out_busy) begin
               cmd.emit = 1'b1;
               state_in = esc_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = esc_pkg::S_IDLE;
         end
      endcase
   end

endmodule

@@ rtl/core/esc_dpath.sv @@
// Datapath of the calendar unit: constant divisions by reciprocal multiply,
// year and month walkers, result register. Depends on esc_pkg and the macro header.
`include "epoch_seconds_to_calendar_unit_macros.svh"

module esc_dpath #(
   parameter int STAMP_BITS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [31:0]      stamp,
   input  esc_pkg::cmd_type cmd,
   output esc_pkg::sts_type sts,
   input  logic             rsp_tready,
   output logic             rsp_tvalid,
   output logic [47:0]      rsp_tdata
);

   localparam logic [31:0] STAMP_MASK = (STAMP_BITS >= 32) ? 32'hFFFF_FFFF :
                                        32'((64'd1 << STAMP_BITS) - 64'd1);

   // intermediate and result fields
   logic [31:0] stamp_ff, stamp_in;
   logic [15:0] days_ff, days_in;
   logic [16:0] secs_ff, secs_in;
   logic [13:0] wq_ff, wq_in;
   logic [11:0] rem_ff, rem_in;
   logic [17:0] left_ff, left_in;
   logic [11:0] year_ff, year_in;
   logic [8:0]  cyc_ff, cyc_in;
   logic [3:0]  month_ff, month_in;
   logic [2:0]  wday_ff, wday_in;
   logic [4:0]  hour_ff, hour_in;
   logic [5:0]  minute_ff, minute_in;

   logic [47:0] rsp_tdata_ff, rsp_tdata_in;
   logic        rsp_tvalid_ff, rsp_tvalid_in;

   // constant divisions
   logic [50:0] day_prod;
   logic [31:0] day_span;
   logic [31:0] secs_diff;
   logic [32:0] week_prod;
   logic [15:0] week_span;
   logic [15:0] week_rem;
   logic [26:0] hour_prod;
   logic [16:0] hour_span;
   logic [16:0] hour_rem;
   logic [20:0] min_prod;
   logic [11:0] min_span;
   logic [11:0] min_rem;

   logic        leap;
   logic [8:0]  ylen;
   logic [4:0]  mlen;
   logic [3:0]  wsum;
   logic [4:0]  dom;
   logic [3:0]  month_num;

   assign day_prod  = 51'(stamp_ff[31:7]) * 51'(esc_pkg::DAY_RECIP);
   assign day_span  = 32'(days_ff) * 32'(esc_pkg::SECS_PER_DAY);
   assign secs_diff = stamp_ff - day_span;
   assign week_prod = 33'(days_ff) * 33'(esc_pkg::WEEK_RECIP);
   assign week_span = 16'(wq_ff) * 16'(esc_pkg::DAYS_PER_WEEK);
   assign week_rem  = days_ff - week_span;
   assign hour_prod = 27'(secs_ff[16:4]) * 27'(esc_pkg::HOUR_RECIP);
   assign hour_span = 17'(hour_ff) * 17'(esc_pkg::SECS_PER_HOUR);
   assign hour_rem  = secs_ff - hour_span;
   assign min_prod  = 21'(rem_ff[11:2]) * 21'(esc_pkg::MIN_RECIP);
   assign min_span  = 12'(minute_ff) * 12'(esc_pkg::SECS_PER_MIN);
   assign min_rem   = rem_ff - min_span;

   assign leap = (year_ff[1:0] == 2'd0) && (cyc_ff != 9'd100) &&
                 (cyc_ff != 9'd200) && (cyc_ff != 9'd300);
   assign ylen = leap ? 9'd366 : 9'd365;
   assign mlen = esc_pkg::month_len(month_ff, leap);

   assign wsum      = {1'b0, week_rem[2:0]} + esc_pkg::EPOCH_WDAY;
   assign dom       = left_ff[4:0] + 5'd1;
   assign month_num = month_ff + 4'd1;

   assign sts.year_done  = left_ff < 18'(ylen);
   assign sts.month_done = (left_ff < 18'(mlen)) || (month_ff == esc_pkg::LAST_MONTH);
   assign sts.out_busy   = rsp_tvalid_ff && !rsp_tready;

   always_comb begin
      stamp_in  = stamp_ff;
      days_in   = days_ff;
      secs_in   = secs_ff;
      wq_in     = wq_ff;
      rem_in    = rem_ff;
      left_in   = left_ff;
      year_in   = year_ff;
      cyc_in    = cyc_ff;
      month_in  = month_ff;
      wday_in   = wday_ff;
      hour_in   = hour_ff;
      minute_in = minute_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;

      if (cmd.load) begin
         stamp_in = stamp & STAMP_MASK;
         month_in = '0;
      end

      if (cmd.calc_step) begin
         case (cmd.op)
            esc_pkg::OP_DAY: begin
               days_in = day_prod[50:35];
            end
            esc_pkg::OP_SECS: begin
               secs_in = secs_diff[16:0];
               wq_in   = week_prod[32:19];
               left_in = {2'd0, days_ff};
               year_in = esc_pkg::EPOCH_YEAR;
               cyc_in  = esc_pkg::EPOCH_CYC_POS;
            end
            esc_pkg::OP_WDAY: begin
               wday_in = (wsum >= 4'd7) ? 3'(wsum - 4'd7) : wsum[2:0];
               hour_in = hour_prod[25:21];
            end
            esc_pkg::OP_HOUR: begin
               rem_in = hour_rem[11:0];
            end
            esc_pkg::OP_MIN: begin
               minute_in = min_prod[19:14];
            end
            default: begin
               rem_in = rem_ff;
            end
         endcase
      end

      if (cmd.year_step && !sts.year_done) begin
         left_in = left_ff - 18'(ylen);
         year_in = year_ff + 12'd1;
         cyc_in  = (cyc_ff == esc_pkg::LAST_CYC_POS) ? 9'd0 : cyc_ff + 9'd1;
      end

      if (cmd.month_step && !sts.month_done) begin
         left_in  = left_ff - 18'(mlen);
         month_in = month_ff + 4'd1;
      end

      if (cmd.emit) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = {7'd0, min_rem[5:0], minute_ff, hour_ff, wday_ff, dom,
                          month_num, year_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      stamp_ff     <= stamp_in;
      days_ff      <= days_in;
      secs_ff      <= secs_in;
      wq_ff        <= wq_in;
      rem_ff       <= rem_in;
      left_ff      <= left_in;
      year_ff      <= year_in;
      cyc_ff       <= cyc_in;
      month_ff     <= month_in;
      wday_ff      <= wday_in;
      hour_ff      <= hour_in;
      minute_ff    <= minute_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   `ESC_ASSERT_IMPL(a_emit_range, cmd.emit, (left_ff < 18'd31) && (month_ff < 4'd12), "bad date")
   `ESC_ASSERT_NEXT(a_year_shrinks, cmd.year_step && !sts.year_done, left_ff < $past(left_ff), "year stuck")
   `ESC_ASSERT_NEXT(a_wday_range, cmd.calc_step && (cmd.op == esc_pkg::OP_WDAY), wday_ff < 3'd7, "bad weekday")

endmodule

@@ rtl/core/epoch_seconds_to_calendar_unit.sv @@
// Epoch seconds to UTC calendar date/time converter, top level.
// Channels: req_ takes one 32-bit beat of seconds since 1970-01-01 00:00 UTC
// in req_tdata; rsp_ gives one beat per request with the broken-down date.
// The unit works on one request at a time. req_tready is high only while the
// sequencer is idle. An accepted request then goes through constant divisions
// by reciprocal multiply (days, seconds of day, weekday, hour, minute). The
// year walk then takes off one year length per step from 1970 on, the month
// walk one month length per step, and the emit step loads the result
// register once it is free, the result showing on rsp_tvalid the cycle after
// that.
// The result register is separate from the working registers, so the next
// request is taken while an earlier result still waits on rsp_tready; a
// finished result holds in the sequencer only if the register is still full,
// and req_tready stays low until it moves.
// Reset (synchronous, active high) empties the result register and returns
// the sequencer to idle. No clearing pass is needed.
module epoch_seconds_to_calendar_unit #(
   parameter int STAMP_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] epoch_seconds
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [11:0] year, [15:12] month, [20:16] day_of_month, [23:21] day_of_week,
   // [28:24] hour, [34:29] minute, [40:35] second, [47:41] zero
   output logic [47:0] rsp_tdata
);

   esc_pkg::cmd_type cmd;
   esc_pkg::sts_type sts;

   esc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   esc_dpath #(
      .STAMP_BITS (STAMP_BITS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .stamp      (req_tdata),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

@@ verif/tb.sv @@
// Testbench for epoch_seconds_to_calendar_unit: calendar corner stamps, then random
// stamps and dates under random idling and a long output stall, checked beat by beat.
// Depends on the RTL in rtl/core (esc_pkg and the top level).

module tb;

   typedef struct packed {
      logic [6:0]  pad;
      logic [5:0]  second;
      logic [5:0]  minute;
      logic [4:0]  hour;
      logic [2:0]  day_of_week;
      logic [4:0]  day_of_month;
      logic [3:0]  month;
      logic [11:0] year;
   } calendar_beat_type;

   class calendar_scoreboard;
      calendar_beat_type pending_dates[$];
      int                failures = 0;

      static function bit is_leap(int unsigned y);
         return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
      endfunction

      static function int unsigned month_length(int unsigned m, bit leap);
         case (m)
            2:          return leap ? 29 : 28;
            4, 6, 9, 11: return 30;
            default:    return 31;
         endcase
      endfunction

      function calendar_beat_type to_calendar(logic [31:0] stamp);
         calendar_beat_type c;
         longint unsigned   days;
         longint unsigned   rest;
         longint unsigned   dom;
         int unsigned       secs;
         int unsigned       yr;
         int unsigned       mon;
         bit                leap;
         days = longint'(stamp) / 86400;
         secs = int'(longint'(stamp) % 86400);
         c = '0;
         c.day_of_week = 3'((days + 4) % 7);
         yr = 1970 + int'(days / 146097) * 400;
         rest = days % 146097;
         forever begin
            leap = is_leap(yr);
            if (rest < (leap ? 366 : 365)) break;
            rest -= leap ? 366 : 365;
            yr++;
         end
         dom = rest + 1;
         mon = 1;
         while (mon < 12 && dom > month_length(mon, leap)) begin
            dom -= month_length(mon, leap);
            mon++;
         end
         c.year         = 12'(yr);
         c.month        = 4'(mon);
         c.day_of_month = 5'(dom);
         c.hour         = 5'(secs / 3600);
         c.minute       = 6'((secs % 3600) / 60);
         c.second       = 6'(secs % 60);
         return c;
      endfunction

      function void note_stamp(logic [31:0] stamp);
         pending_dates.push_back(to_calendar(stamp));
      endfunction

      task report(string msg);
         $display("[%0t] MISMATCH %s", $time, msg);
         failures++;
      endtask

      task check_field(string name, int unsigned got, int unsigned want);
         if (got != want) begin
            report($sformatf("%s: got %0d, expected %0d", name, got, want));
         end
      endtask

      task check_beat(logic [47:0] data);
         calendar_beat_type got;
         calendar_beat_type want;
         got = data;
         if (pending_dates.size() == 0) begin
            report($sformatf("unexpected result beat %h", data));
         end else begin
            want = pending_dates.pop_front();
            check_field("year", got.year, want.year);
            check_field("month", got.month, want.month);
            check_field("day_of_month", got.day_of_month, want.day_of_month);
            check_field("day_of_week", got.day_of_week, want.day_of_week);
            check_field("hour", got.hour, want.hour);
            check_field("minute", got.minute, want.minute);
            check_field("second", got.second, want.second);
            check_field("pad", got.pad, want.pad);
         end
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // [31:0] epoch_seconds
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // [11:0] year, [15:12] month, [20:16] day_of_month, [23:21] day_of_week,
   // [28:24] hour, [34:29] minute, [40:35] second, [47:41] zero
   logic [47:0] rsp_tdata;

   logic        rx_hold = 1'b0;
   int          send_idle = 24;
   int          recv_idle = 74;
   logic [31:0] corner_stamps[$];

   calendar_scoreboard sb = new();

   epoch_seconds_to_calendar_unit #(
      .STAMP_BITS(32)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #10 clock = ~clock;

   function automatic logic [31:0] stamp_of(input int unsigned y, mo, d, h, mi, s);
      longint unsigned days;
      days = d - 1;
      for (int unsigned yy = 1970; yy < y; yy++) begin
         days += calendar_scoreboard::is_leap(yy) ? 366 : 365;
      end
      for (int unsigned mm = 1; mm < mo; mm++) begin
         days += calendar_scoreboard::month_length(mm, calendar_scoreboard::is_leap(y));
      end
      return 32'(days * 86400 + h * 3600 + mi * 60 + s);
   endfunction

   function automatic int unsigned corner_or_any(int unsigned lo, int unsigned hi);
      case ($urandom_range(2))
         0:       return lo;
         1:       return hi;
         default: return $urandom_range(hi, lo);
      endcase
   endfunction

   task automatic send_stamp(input logic [31:0] stamp);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= stamp;
      do @(posedge clock); while (!req_tready);
      sb.note_stamp(stamp);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (sb.pending_dates.size() != 0) @(posedge clock);
   endtask

   task automatic run_random(int unsigned count);
      int unsigned y;
      int unsigned mo;
      logic [31:0] stamp;
      for (int unsigned i = 0; i < count; i++) begin
         case ($urandom_range(9))
            0, 1, 2, 3: stamp = $urandom;
            8:          stamp = $urandom_range(200000);
            9:          stamp = 32'hFFFF_FFFF - $urandom_range(100000);
            default: begin
               // well-formed date, biased to month, day and year rollovers
               y  = $urandom_range(2106, 1970);
               mo = corner_or_any(1, 12);
               stamp = stamp_of(y, mo,
                  corner_or_any(1, calendar_scoreboard::month_length(mo,
                     calendar_scoreboard::is_leap(y))),
                  corner_or_any(0, 23), corner_or_any(0, 59), corner_or_any(0, 59));
            end
         endcase
         send_stamp(stamp);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) sb.check_beat(rsp_tdata);
         rsp_tready <= !rx_hold && ($urandom_range(99) >= recv_idle);
      end
   end

   initial begin
      corner_stamps = '{
         32'h0000_0000,
         stamp_of(1970, 1, 1, 23, 59, 59),
         stamp_of(1970, 2, 28, 23, 59, 59),
         stamp_of(1970, 3, 1, 0, 0, 0),
         stamp_of(1971, 12, 31, 23, 59, 59),
         stamp_of(1972, 2, 29, 12, 0, 0),
         stamp_of(1972, 12, 31, 23, 59, 59),
         stamp_of(1973, 1, 1, 0, 0, 0),
         stamp_of(1985, 4, 30, 23, 59, 59),
         stamp_of(1985, 11, 30, 11, 30, 30),
         stamp_of(1999, 12, 31, 23, 59, 59),
         stamp_of(2000, 2, 29, 0, 0, 0),
         stamp_of(2000, 12, 31, 23, 59, 59),
         32'h7FFF_FFFF,
         32'h8000_0000,
         stamp_of(2100, 2, 28, 23, 59, 59),
         stamp_of(2100, 3, 1, 0, 0, 0),
         stamp_of(2104, 2, 29, 6, 30, 30),
         stamp_of(2105, 12, 31, 23, 59, 59),
         stamp_of(2106, 1, 1, 0, 0, 0),
         32'hFFFF_FFFE,
         32'hFFFF_FFFF
      };
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (corner_stamps[i]) send_stamp(corner_stamps[i]);
      wait_drained();

      // long output stall while input keeps coming; unit must back-pressure
      fork
         begin
            rx_hold <= 1'b1;
            repeat (500) @(posedge clock);
            rx_hold <= 1'b0;
         end
      join_none
      run_random(320);
      wait_drained();

      send_idle <= 74;
      recv_idle <= 24;
      run_random(320);

      send_idle <= 0;
      recv_idle <= 0;
      run_random(310);
      wait_drained();

      repeat (300) @(posedge clock);
      if (sb.failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #30_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/esc_pkg.sv
rtl/core/esc_ctrl.sv
rtl/core/esc_dpath.sv
rtl/core/epoch_seconds_to_calendar_unit.sv
verif/tb.sv
